[design/sga_pkg.sv]
// ----------------------------------------------------------------------------
// sga_pkg: shared types and constants
// Fixed-point widths, command record, register selects and back-end states.
// ----------------------------------------------------------------------------
package sga_pkg;

    localparam int POS_W   = 32;   // Q16.16 coordinate
    localparam int IDX_W   = 10;   // body index field
    localparam int CNT_W   = 11;   // body_count register
    localparam int SOFT_W  = 32;   // softening_sq register
    localparam int ACC_W   = 48;   // Q24.24 sum
    localparam int MAG_W   = 32;   // |displacement|
    localparam int DIFF_W  = 33;   // signed displacement
    localparam int R2_W    = 66;   // squared distance (and r2 + softening)
    localparam int ROOT_W  = 34;   // floor(sqrt(r2))
    localparam int DEN_W   = 100;  // (r2 + soft) * r
    localparam int NUM_W   = 88;   // |d| << 56
    localparam int TERM_W  = 49;   // capped quotient magnitude
    localparam int MUL_W   = 34;   // shared multiplier operand
    localparam int PROD_W  = 68;
    localparam int CHUNK_W = 22;   // r2 + soft is multiplied in three slices
    localparam int J_W     = 12;   // body loop counter, holds 2047 + 1
    localparam int SUM_W   = 50;   // accumulator plus term, before clipping
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int FIFO_DEPTH = 2;

    localparam int MAX_BODIES_DEF = 1024;

    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_SOFTENING  = 1'b0,
        REG_BODY_COUNT = 1'b1
    } reg_sel_t;

    typedef struct packed {
        op_t                     op;
        logic                    in_range;
        logic [IDX_W-1:0]        idx;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        z;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SELF,
        B_FETCH,
        B_DIFF,
        B_SQ,
        B_CHK,
        B_SQRT,
        B_MUL,
        B_DSTART,
        B_DWAIT,
        B_RESULT
    } back_state_t;

endpackage

[design/sga_front.sv]
// ----------------------------------------------------------------------------
// sga_front: request intake
// Accepts requests, drops loads beyond the store, queues the rest.
// ----------------------------------------------------------------------------
module sga_front #(
    parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        op,
    input  logic [sga_pkg::IDX_W-1:0]   body_index,
    input  logic [sga_pkg::POS_W-1:0]   pos_x,
    input  logic [sga_pkg::POS_W-1:0]   pos_y,
    input  logic [sga_pkg::POS_W-1:0]   pos_z,
    output logic                        cmd_valid,
    output sga_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);
    import sga_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW   = $clog2(FIFO_DEPTH + 1);
    localparam logic [FCW-1:0] FULL = FCW'(FIFO_DEPTH);

    cmd_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0]   fill_reg, fill_next;
    cmd_t             in_cmd;
    logic             accept;
    logic             push;
    logic             pop;

    always_comb
    begin
        in_cmd.op       = op_t'(op);
        in_cmd.in_range = (32'(body_index) < MAX_BODIES);
        in_cmd.idx      = body_index;
        in_cmd.x        = pos_x;
        in_cmd.y        = pos_y;
        in_cmd.z        = pos_z;
    end

    assign item_stall = (fill_reg == FULL);
    assign accept     = item_valid && !item_stall;
    // a load outside the store has no effect at all
    assign push       = accept && (in_cmd.in_range || in_cmd.op == OP_QUERY);
    assign cmd_valid  = (fill_reg != '0);
    assign pop        = cmd_pop && cmd_valid;
    assign cmd        = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = FCW'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = FCW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[design/sga_isqrt.sv]
// ----------------------------------------------------------------------------
// sga_isqrt: integer square root
// Digit-by-digit, one result bit per cycle, floor(sqrt(value)).
// ----------------------------------------------------------------------------
module sga_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sga_pkg::R2_W-1:0]    value,
    output logic                        done,
    output logic [sga_pkg::ROOT_W-1:0]  root
);
    import sga_pkg::*;

    localparam int VW  = 2 * ROOT_W;
    localparam int RW  = ROOT_W + 2;
    localparam int SW  = RW + 2;
    localparam int CW  = $clog2(ROOT_W + 1);
    localparam logic [CW-1:0] ITERS = CW'(ROOT_W);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [VW-1:0]     val_reg;
    logic [RW-1:0]     rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SW-1:0]     rem_sh;
    logic [SW-1:0]     trial;
    logic              ge;

    assign rem_sh = {rem_reg, val_reg[VW-1 -: 2]};
    assign trial  = {{(SW-ROOT_W-2){1'b0}}, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITERS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CW'(cnt_reg - 1'b1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= VW'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[VW-3:0], 2'b00};
            rem_reg  <= RW'(ge ? (rem_sh - trial) : rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

endmodule

[design/sga_qdiv.sv]
// ----------------------------------------------------------------------------
// sga_qdiv: capped term divider
// Restoring division of |d| << 56 by the pair denominator, one bit per cycle.
// ----------------------------------------------------------------------------
module sga_qdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sga_pkg::MAG_W-1:0]   mag,
    input  logic [sga_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [sga_pkg::TERM_W-1:0]  quo
);
    import sga_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);
    localparam logic [CW-1:0] ITERS = CW'(NUM_W);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});
    assign done   = done_reg;
    // prefixes of the quotient only grow, so clamping the final value is
    // the same as stopping once it passes the cap
    assign quo    = (q_reg > NUM_W'(TERM_CAP)) ? TERM_CAP : q_reg[TERM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITERS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CW'(cnt_reg - 1'b1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag, {(NUM_W-MAG_W){1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= DEN_W'(ge ? (rem_sh - {1'b0, den_reg}) : rem_sh);
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

endmodule

[design/sga_back.sv]
// ----------------------------------------------------------------------------
// sga_back: position store and pair sequencer
// Executes loads and walks every counted body for a query, one pair at a time.
// ----------------------------------------------------------------------------
module sga_back #(
    parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  sga_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    input  logic [sga_pkg::SOFT_W-1:0]        soft_len_sq,
    input  logic [sga_pkg::CNT_W-1:0]         body_count,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [sga_pkg::IDX_W-1:0]         result_index,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_x,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_y,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_z,
    output logic                              saturated,
    output logic                              coincident
);
    import sga_pkg::*;

    localparam int ADDR_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam logic [16:0] MAX_L = 17'(MAX_BODIES);

    back_state_t state_reg, state_next;

    // store
    logic [3*POS_W-1:0] mem [MAX_BODIES];
    logic [3*POS_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;

    // query context
    logic [IDX_W-1:0]         idx_reg;
    logic [J_W-1:0]           j_reg;
    logic [J_W-1:0]           count_eff;
    logic [POS_W-1:0]         self_reg [3];
    logic [MAG_W-1:0]         mag_reg  [3];
    logic                     neg_reg  [3];
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic                     sat_reg;
    logic                     coin_reg;
    logic [1:0]               step_reg;
    logic [1:0]               axis_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [R2_W-1:0]          q_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DEN_W-1:0]         den_reg;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod_reg;

    // units
    logic              sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              div_start, div_done;
    logic [TERM_W-1:0] div_quo;

    // differences
    logic [POS_W-1:0]        rd_pos [3];
    logic signed [DIFF_W-1:0] diff  [3];

    // accumulate
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    logic [ACC_W-1:0]        sum_clip;
    logic                    sum_ovf;

    // result register
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [ACC_W-1:0] out_acc_reg [3];
    logic                    out_sat_reg;
    logic                    out_coin_reg;
    logic                    out_free;

    logic self_pair;
    logic j_done;

    assign count_eff = ({6'b0, body_count} > MAX_L) ? J_W'(MAX_L) : J_W'(body_count);
    assign self_pair = (j_reg == J_W'(idx_reg));
    assign j_done    = (j_reg >= count_eff);
    assign out_free  = !out_valid_reg || !result_stall;

    assign rd_pos[0] = rd_data_reg[3*POS_W-1 -: POS_W];
    assign rd_pos[1] = rd_data_reg[2*POS_W-1 -: POS_W];
    assign rd_pos[2] = rd_data_reg[POS_W-1:0];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = {rd_pos[a][POS_W-1], rd_pos[a]} - {self_reg[a][POS_W-1], self_reg[a]};
        end
    end

    // signed term and clipped running sum
    always_comb
    begin
        term = neg_reg[axis_reg] ? -SUM_W'(div_quo) : SUM_W'(div_quo);
        sum  = SUM_W'(acc_reg[axis_reg]) + term;
        sum_ovf = (sum[SUM_W-1:ACC_W-1] != '0) && (sum[SUM_W-1:ACC_W-1] != '1);
        if (!sum_ovf)
        begin
            sum_clip = sum[ACC_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sum_clip = ACC_MIN;
        end
        else
        begin
            sum_clip = ACC_MAX;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_QUERY)
                begin
                    state_next = cmd.in_range ? B_SELF : B_RESULT;
                end
            end
            B_SELF:   state_next = B_FETCH;
            B_FETCH:
            begin
                if (j_done)
                begin
                    state_next = B_RESULT;
                end
                else if (!self_pair)
                begin
                    state_next = B_DIFF;
                end
            end
            B_DIFF:   state_next = B_SQ;
            B_SQ:     state_next = (step_reg == 2'd3) ? B_CHK : B_SQ;
            B_CHK:    state_next = (r2_reg == '0) ? B_FETCH : B_SQRT;
            B_SQRT:   state_next = sqrt_done ? B_MUL : B_SQRT;
            B_MUL:    state_next = (step_reg == 2'd3) ? B_DSTART : B_MUL;
            B_DSTART: state_next = B_DWAIT;
            B_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == 2'd2) ? B_FETCH : B_DSTART;
                end
            end
            B_RESULT: state_next = out_free ? B_IDLE : B_RESULT;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = ADDR_W'(j_reg);
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                cmd_pop = cmd_valid;
                mem_we  = cmd_valid && (cmd.op == OP_LOAD);
                rd_addr = ADDR_W'(cmd.idx);
            end
            B_SQ:
            begin
                if (step_reg != 2'd3)
                begin
                    mul_a = MUL_W'(mag_reg[step_reg]);
                    mul_b = MUL_W'(mag_reg[step_reg]);
                end
            end
            B_CHK:    sqrt_start = (r2_reg != '0);
            B_MUL:
            begin
                mul_b = root_reg;
                unique case (step_reg)
                    2'd0:    mul_a = MUL_W'(q_reg[0 +: CHUNK_W]);
                    2'd1:    mul_a = MUL_W'(q_reg[CHUNK_W +: CHUNK_W]);
                    2'd2:    mul_a = MUL_W'(q_reg[2*CHUNK_W +: CHUNK_W]);
                    default: mul_a = '0;
                endcase
            end
            B_DSTART: div_start = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ADDR_W'(cmd.idx)] <= {cmd.x, cmd.y, cmd.z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_QUERY)
                begin
                    idx_reg  <= cmd.idx;
                    j_reg    <= '0;
                    sat_reg  <= 1'b0;
                    coin_reg <= 1'b0;
                    for (int a = 0; a < 3; a++)
                    begin
                        acc_reg[a] <= '0;
                    end
                end
            end
            B_SELF:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    self_reg[a] <= rd_pos[a];
                end
            end
            B_FETCH:
            begin
                if (!j_done && self_pair)
                begin
                    j_reg <= J_W'(j_reg + 1'b1);
                end
            end
            B_DIFF:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    neg_reg[a] <= diff[a][DIFF_W-1];
                    mag_reg[a] <= MAG_W'(diff[a][DIFF_W-1] ? -diff[a] : diff[a]);
                end
                step_reg <= '0;
                r2_reg   <= '0;
            end
            B_SQ:
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg != 2'd0)
                begin
                    r2_reg <= r2_reg + R2_W'(prod_reg);
                end
            end
            B_CHK:
            begin
                q_reg    <= r2_reg + R2_W'({soft_len_sq, 16'b0});
                step_reg <= '0;
                den_reg  <= '0;
                if (r2_reg == '0)
                begin
                    // coincident pair adds nothing
                    coin_reg <= 1'b1;
                    j_reg    <= J_W'(j_reg + 1'b1);
                end
            end
            B_SQRT:
            begin
                if (sqrt_done)
                begin
                    root_reg <= sqrt_root;
                end
            end
            B_MUL:
            begin
                step_reg <= step_reg + 2'd1;
                axis_reg <= '0;
                unique case (step_reg)
                    2'd1:    den_reg <= den_reg + DEN_W'(prod_reg);
                    2'd2:    den_reg <= den_reg + (DEN_W'(prod_reg) << CHUNK_W);
                    2'd3:    den_reg <= den_reg + (DEN_W'(prod_reg) << (2*CHUNK_W));
                    default:
                    begin
                    end
                endcase
            end
            B_DWAIT:
            begin
                if (div_done)
                begin
                    acc_reg[axis_reg] <= sum_clip;
                    if (sum_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (axis_reg == 2'd2)
                    begin
                        j_reg <= J_W'(j_reg + 1'b1);
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
            end
            B_RESULT:
            begin
                if (out_free)
                begin
                    out_idx_reg  <= idx_reg;
                    out_sat_reg  <= sat_reg;
                    out_coin_reg <= coin_reg;
                    for (int a = 0; a < 3; a++)
                    begin
                        out_acc_reg[a] <= acc_reg[a];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    sga_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (r2_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    sga_qdiv u_qdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag_reg[axis_reg]),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign result_valid = out_valid_reg;
    assign result_index = out_idx_reg;
    assign acc_x        = out_acc_reg[0];
    assign acc_y        = out_acc_reg[1];
    assign acc_z        = out_acc_reg[2];
    assign saturated    = out_sat_reg;
    assign coincident   = out_coin_reg;

endmodule

[design/softened_gravity_accel_top.sv]
// ----------------------------------------------------------------------------
// softened_gravity_accel_top: softened direct-sum gravity engine
// Position store with load and query requests; query returns a saturated
// Q24.24 acceleration summed over all other counted bodies.
// ----------------------------------------------------------------------------
//   channel   handshake                       payload
//   item      item_valid / item_stall         op, body_index, pos_x/y/z
//   result    result_valid / result_stall     result_index, acc_x/y/z,
//                                             saturated, coincident
//   config    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A load is written to the store without the back end leaving idle. A query
// walks every other counted body in turn, skipping itself and cutting a coincident
// one short: the 34-step root unit and three passes of the 88-step divider
// dominate each pair.
// The request queue holds two requests, so intake goes on, until the queue is
// full, while a query runs or a result waits under result_stall.
// Reset clears control and both registers; the store is not cleared.
// ----------------------------------------------------------------------------
module softened_gravity_accel_top #(
    parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sga_pkg::PADDR_W-1:0]       paddr,
    input  logic [sga_pkg::PDATA_W-1:0]       pwdata,
    output logic [sga_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // requests
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              op,
    input  logic [sga_pkg::IDX_W-1:0]         body_index,
    input  logic signed [sga_pkg::POS_W-1:0]  pos_x,
    input  logic signed [sga_pkg::POS_W-1:0]  pos_y,
    input  logic signed [sga_pkg::POS_W-1:0]  pos_z,
    // results
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [sga_pkg::IDX_W-1:0]         result_index,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_x,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_y,
    output logic signed [sga_pkg::ACC_W-1:0]  acc_z,
    output logic                              saturated,
    output logic                              coincident
);
    import sga_pkg::*;

    logic [SOFT_W-1:0] softening_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              cfg_wr;
    reg_sel_t          reg_sel;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // register select is the word address; wider byte offsets alias
    assign reg_sel = reg_sel_t'(paddr[2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_SOFTENING:  prdata = softening_reg;
            REG_BODY_COUNT: prdata = PDATA_W'(count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_reg <= '0;
            count_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SOFTENING:  softening_reg <= pwdata;
                REG_BODY_COUNT: count_reg     <= pwdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // intake and classification
    sga_front #(
        .MAX_BODIES (MAX_BODIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .body_index (body_index),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // store, pair loop and result register
    sga_back #(
        .MAX_BODIES (MAX_BODIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .soft_len_sq  (softening_reg),
        .body_count   (count_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_index (result_index),
        .acc_x        (acc_x),
        .acc_y        (acc_y),
        .acc_z        (acc_z),
        .saturated    (saturated),
        .coincident   (coincident)
    );

endmodule

[design/sga_checker.sv]
// ----------------------------------------------------------------------------
// sga_checker: port-level checks
// Result handshake and register readback, bound to the top level.
// ----------------------------------------------------------------------------
module sga_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [sga_pkg::PADDR_W-1:0]       paddr,
    input logic [sga_pkg::PDATA_W-1:0]       pwdata,
    input logic [sga_pkg::PDATA_W-1:0]       prdata,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic signed [sga_pkg::ACC_W-1:0]  acc_x,
    input logic [sga_pkg::IDX_W-1:0]         result_index
);
    import sga_pkg::*;

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(acc_x) && $stable(result_index))
        else $error("result payload changed while stalled");

    a_soft_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
        |-> prdata == $past(pwdata))
        else $error("softening readback mismatch");

    a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2]) ##1 (psel && !pwrite && paddr[2])
        |-> prdata == PDATA_W'($past(pwdata[CNT_W-1:0])))
        else $error("body count readback mismatch");

endmodule

bind softened_gravity_accel_top sga_checker u_sga_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .acc_x        (acc_x),
    .result_index (result_index)
);

[tb/softened_gravity_accel_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_accel_top_test: self-checking bench for the gravity engine
// Loads body positions and issues acceleration queries under changing
// softening and body counts. A directed table covers the edge cases, then
// random traffic runs under three idle patterns. Every query result is
// checked against a bit-exact fixed-point model of the direct sum or a typed row.
// ----------------------------------------------------------------------------
module softened_gravity_accel_top_test;
    import sga_pkg::*;

    localparam int NBODY     = 1024;
    localparam int CYC_LIMIT = 12000000;
    localparam int HOLD_LEN  = 3000;
    localparam logic [127:0] Q_CAP = 128'h1 << 48;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] ax;
        logic [ACC_W-1:0] ay;
        logic [ACC_W-1:0] az;
        logic             sat;
        logic             coin;
    } accel_res_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] x, y, z;
        logic             known;      // expected result typed in the row
        accel_res_t       res;
        reg_sel_t         sel;
        logic [31:0]      val;
    } row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic item_valid, item_stall, op;
    logic [IDX_W-1:0] body_index;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic result_valid, result_stall;
    logic [IDX_W-1:0] result_index;
    logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
    logic saturated, coincident;

    softened_gravity_accel_top DUT (.*);

    // shadow of the block: positions, which entries are valid, registers
    logic signed [POS_W-1:0] pos_sx [NBODY];
    logic signed [POS_W-1:0] pos_sy [NBODY];
    logic signed [POS_W-1:0] pos_sz [NBODY];
    bit                      loaded [NBODY];
    logic [31:0]             soft_reg;
    logic [10:0]             count_reg;

    accel_res_t pending_accel [$];
    int  mismatches;
    int  send_idle_pct, recv_idle_pct;
    bit  hold_go;
    row_t dir_rows [$];

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // --------------------------------------------------------------------
    // Model of the direct sum
    // --------------------------------------------------------------------
    function automatic logic [63:0] isqrt66(logic [127:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= v)
                root = cand;
        end
        return root;
    endfunction

    // one axis: divide, cap, apply sign, add with saturation
    function automatic longint accum_axis(longint acc, longint d, logic [127:0] den,
                                          ref bit clip);
        logic [127:0] mag;
        logic [127:0] qt;
        longint       t, s;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        qt  = (mag << 56) / den;
        if (qt > Q_CAP)
            qt = Q_CAP;
        t = (d < 0) ? -longint'(qt) : longint'(qt);
        s = acc + t;
        if (s > longint'(ACC_MAX) && s > 0)
        begin
            s = (64'sd1 <<< 47) - 1;
            clip = 1'b1;
        end
        else if (s < -(64'sd1 <<< 47))
        begin
            s = -(64'sd1 <<< 47);
            clip = 1'b1;
        end
        return s;
    endfunction

    function automatic accel_res_t gravity_sum(logic [IDX_W-1:0] i);
        accel_res_t   r;
        longint       ax, ay, az, dx, dy, dz;
        logic [127:0] mx, my, mz, r2, qv, den;
        logic [63:0]  root;
        int           cnt;
        bit           clip, coin;
        ax = 0; ay = 0; az = 0;
        clip = 0; coin = 0;
        cnt = (count_reg > NBODY) ? NBODY : int'(count_reg);
        for (int j = 0; j < cnt; j++)
        begin
            if (j == int'(i))
                continue;
            dx = longint'(pos_sx[j]) - longint'(pos_sx[i]);
            dy = longint'(pos_sy[j]) - longint'(pos_sy[i]);
            dz = longint'(pos_sz[j]) - longint'(pos_sz[i]);
            mx = (dx < 0) ? 128'(-dx) : 128'(dx);
            my = (dy < 0) ? 128'(-dy) : 128'(dy);
            mz = (dz < 0) ? 128'(-dz) : 128'(dz);
            r2 = mx * mx + my * my + mz * mz;
            if (r2 == 0)
            begin
                coin = 1'b1;
                continue;
            end
            qv   = r2 + ({96'd0, soft_reg} << 16);
            root = isqrt66(r2);
            den  = qv * {64'd0, root};
            ax = accum_axis(ax, dx, den, clip);
            ay = accum_axis(ay, dy, den, clip);
            az = accum_axis(az, dz, den, clip);
        end
        r.idx  = i;
        r.ax   = ax[ACC_W-1:0];
        r.ay   = ay[ACC_W-1:0];
        r.az   = az[ACC_W-1:0];
        r.sat  = clip;
        r.coin = coin;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Request side
    // --------------------------------------------------------------------
    // Offer one request and return at the edge that takes it; the model
    // is updated at that same edge.
    task automatic send_request(op_t kind, logic [IDX_W-1:0] idx,
                                logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [POS_W-1:0] z, bit known, accel_res_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= kind;
        body_index <= idx;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (kind == OP_LOAD)
        begin
            pos_sx[idx] = x;
            pos_sy[idx] = y;
            pos_sz[idx] = z;
            loaded[idx] = 1'b1;
        end
        else
        begin
            pending_accel.push_back(known ? res : gravity_sum(idx));
        end
    endtask

    // drain everything, let a trailing load finish
    task automatic drain;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_accel.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // register write only once the block is idle
    task automatic write_reg(reg_sel_t sel, logic [31:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_SOFTENING)
            soft_reg = val;
        else
            count_reg = val[10:0];
    endtask

    // --------------------------------------------------------------------
    // Random content
    // --------------------------------------------------------------------
    function automatic logic [POS_W-1:0] rand_coord(int axis);
        int src;
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3:
            begin
                // copy a loaded body so pairs can coincide
                src = $urandom_range(15);
                if (!loaded[src])
                    return 32'h0;
                return (axis == 0) ? pos_sx[src] : (axis == 1) ? pos_sy[src] : pos_sz[src];
            end
            4: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
            default: return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [10:0] pick_count();
        int c;
        c = $urandom_range(10);
        while (c > 0 && !loaded[c-1])
            c--;
        for (int k = 0; k < c; k++)
            if (!loaded[k])
                c = k;
        return 11'(c);
    endfunction

    task automatic random_items(int n);
        logic [IDX_W-1:0] idx;
        accel_res_t       none;
        none = '0;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 35)
            begin
                idx = 10'($urandom_range(1023));
                if (!loaded[idx])
                    idx = (count_reg == 0) ? 10'd0 : 10'($urandom_range(int'(count_reg) - 1));
                send_request(OP_QUERY, idx, $urandom(), $urandom(), $urandom(), 1'b0, none);
            end
            else
            begin
                idx = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                : 10'($urandom_range(15));
                send_request(OP_LOAD, idx, rand_coord(0), rand_coord(1), rand_coord(2),
                             1'b0, none);
            end
        end
    endtask

    task automatic random_settings;
        logic [31:0] s;
        case ($urandom_range(3))
            0: s = 32'h0;
            1: s = 32'hFFFF_FFFF;
            default: s = $urandom();
        endcase
        write_reg(REG_SOFTENING, s);
        write_reg(REG_BODY_COUNT, {21'd0, pick_count()});
    endtask

    // --------------------------------------------------------------------
    // Directed table
    // --------------------------------------------------------------------
    function automatic row_t row_load(int idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
        row_t r;
        r = '{kind: ROW_LOAD, idx: IDX_W'(idx), x: x, y: y, z: z, known: 1'b0, res: '0,
              sel: REG_SOFTENING, val: '0};
        return r;
    endfunction

    function automatic row_t row_query(int idx, bit known);
        row_t r;
        r = '{kind: ROW_QUERY, idx: IDX_W'(idx), x: '0, y: '0, z: '0, known: known,
              res: '0, sel: REG_SOFTENING, val: '0};
        r.res.idx = IDX_W'(idx);   // typed rows expect all zero sums and flags
        return r;
    endfunction

    function automatic row_t row_cfg(reg_sel_t sel, logic [31:0] val);
        row_t r;
        r = '{kind: ROW_CFG, idx: '0, x: '0, y: '0, z: '0, known: 1'b0, res: '0,
              sel: sel, val: val};
        return r;
    endfunction

    task automatic build_table;
        dir_rows.push_back(row_load(0, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(row_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_rows.push_back(row_load(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(row_load(3, 32'h0001_0000, 32'h0, 32'h0));
        dir_rows.push_back(row_load(1023, 32'h0, 32'h0001_0000, 32'hFFFF_0000));
        // no counted bodies after reset: empty sums
        dir_rows.push_back(row_query(0, 1));
        dir_rows.push_back(row_query(1023, 1));
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 4));
        dir_rows.push_back(row_query(0, 0));
        dir_rows.push_back(row_query(1, 0));
        dir_rows.push_back(row_query(2, 0));
        dir_rows.push_back(row_query(3, 0));
        dir_rows.push_back(row_query(1023, 0));     // queried body outside the count
        // body 4 sits on body 0: coincident pair
        dir_rows.push_back(row_load(4, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 5));
        dir_rows.push_back(row_query(0, 0));
        dir_rows.push_back(row_query(4, 0));
        dir_rows.push_back(row_cfg(REG_SOFTENING, 32'hFFFF_FFFF));
        dir_rows.push_back(row_query(3, 0));
        // one LSB away from body 0: huge term, capped and saturated
        dir_rows.push_back(row_load(5, 32'h1, 32'h0, 32'h0));
        dir_rows.push_back(row_cfg(REG_SOFTENING, 0));
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 6));
        dir_rows.push_back(row_query(0, 0));
        dir_rows.push_back(row_query(5, 0));
        // count at and above the store size; only loads run under these
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 1024));
        dir_rows.push_back(row_load(6, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000));
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 2047));
        dir_rows.push_back(row_load(7, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000));
        dir_rows.push_back(row_cfg(REG_BODY_COUNT, 8));
        dir_rows.push_back(row_query(7, 0));
    endtask

    // --------------------------------------------------------------------
    // Result side: stall pattern with one long hold-off
    // --------------------------------------------------------------------
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each taken result against the oldest expected one
    always @(posedge clk)
    begin
        accel_res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_accel.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result for body %0d", result_index);
            end
            else
            begin
                want = pending_accel.pop_front();
                if (result_index !== want.idx || acc_x !== want.ax || acc_y !== want.ay ||
                    acc_z !== want.az || saturated !== want.sat ||
                    coincident !== want.coin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: body %0d exp idx=%0d a=(%h,%h,%h) sat=%b coin=%b, got idx=%0d a=(%h,%h,%h) sat=%b coin=%b",
                                 want.idx, want.idx, want.ax, want.ay, want.az, want.sat,
                                 want.coin, result_index, acc_x, acc_y, acc_z, saturated,
                                 coincident);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYC_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial
    begin
        accel_res_t none;
        row_t       row;
        none = '0;
        mismatches = 0;
        hold_go = 0;
        soft_reg = 0;
        count_reg = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        op           <= OP_LOAD;
        body_index   <= '0;
        pos_x        <= '0;
        pos_y        <= '0;
        pos_z        <= '0;
        result_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part, light idling
        send_idle_pct = 12;
        recv_idle_pct = 20;
        build_table();
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            case (row.kind)
                ROW_LOAD:  send_request(OP_LOAD, row.idx, row.x, row.y, row.z, 1'b0, none);
                ROW_QUERY: send_request(OP_QUERY, row.idx, $urandom(), $urandom(),
                                        $urandom(), row.known, row.res);
                default:   write_reg(row.sel, row.val);
            endcase
        end

        // sender busy, receiver mostly stalled; a long hold-off fills the queue
        send_idle_pct = 12;
        recv_idle_pct = 61;
        random_settings();
        hold_go = 1;
        random_items(95);
        random_settings();
        random_items(95);

        // roles swapped; one pause until all results are back
        send_idle_pct = 61;
        recv_idle_pct = 12;
        random_settings();
        random_items(95);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_accel.size() != 0)
            @(posedge clk);
        random_items(95);

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_settings();
        random_items(95);
        random_settings();
        random_items(95);

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_accel.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
